### src/qph_pkg.sv
// shared constants and types for the quadratic probe hash insert unit
`default_nettype none

package qph_pkg;

  localparam int KEY_W         = 31;
  localparam int SIZE_W        = 11;
  localparam int SLOT_W        = 10;
  localparam int DEPTH_DEFAULT = 1024;
  localparam int PADDR_W       = 3;
  localparam int PDATA_W       = 32;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1021;

  // register index, taken from paddr[2]
  localparam logic REG_TABLE_SIZE = 1'b0;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_DIVIDE = 7'b0000100,
    ST_SETUP  = 7'b0001000,
    ST_READ   = 7'b0010000,
    ST_CHECK  = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic set_fail;
    logic div_step;
    logic probe_init;
    logic advance;
    logic mark;
    logic set_ok;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic size_zero;
    logic div_last;
    logic slot_free;
    logic last_probe;
  } sts_t;

endpackage

`default_nettype wire

### src/qph_ctrl.sv
// controller state machine for the hash insert sequence
`default_nettype none

module qph_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  input  wire qph_pkg::sts_t sts,
  output qph_pkg::cmd_t      cmd
);
  import qph_pkg::*;

  state_t state;
  state_t state_next;
  logic   req_take;
  logic   out_free;

  assign req_stall = (state != ST_IDLE);
  assign req_take  = req_valid && (state == ST_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_take) begin
          cmd.load = 1'b1;
          if (sts.size_zero) begin
            cmd.set_fail = 1'b1;
            state_next   = ST_FINISH;
          end else begin
            state_next = ST_DIVIDE;
          end
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.probe_init = 1'b1;
        state_next     = ST_READ;
      end
      ST_READ: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.slot_free) begin
          cmd.mark   = 1'b1;
          cmd.set_ok = 1'b1;
          state_next = ST_FINISH;
        end else if (sts.last_probe) begin
          cmd.set_fail = 1'b1;
          state_next   = ST_FINISH;
        end else begin
          cmd.advance = 1'b1;
          state_next  = ST_READ;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### src/qph_dp.sv
// datapath: key modulo divider, probe stepping, occupancy memory, result registers
`default_nettype none

module qph_dp #(
  parameter int TABLE_DEPTH = qph_pkg::DEPTH_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [qph_pkg::KEY_W-1:0]   key,
  input  wire logic [qph_pkg::SIZE_W-1:0]  table_size,
  input  wire qph_pkg::cmd_t               cmd,
  output qph_pkg::sts_t                    sts,
  output logic      [qph_pkg::SLOT_W-1:0]  slot,
  output logic                             failed
);
  import qph_pkg::*;

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int PW   = (AW > SIZE_W) ? AW : SIZE_W;
  localparam int CW   = $clog2(KEY_W);

  logic              occ [TABLE_DEPTH];
  logic              rd_data;
  logic [AW-1:0]     clr_addr;

  logic [PW-1:0]     eff_size;
  logic [PW-1:0]     sz;
  logic [KEY_W-1:0]  keysh;
  logic [PW-1:0]     rem;
  logic [CW-1:0]     cnt;
  logic [PW-1:0]     pos;
  logic [PW-1:0]     step;
  logic [PW-1:0]     idx;

  logic [PW:0]       trial;
  logic [PW-1:0]     rem_next;
  logic [PW:0]       pos_sum;
  logic [PW-1:0]     pos_next;
  logic [PW:0]       step_sum;
  logic [PW-1:0]     step_next;

  logic [SLOT_W-1:0] pend_slot;
  logic              pend_failed;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;

  // table_size above the depth saturates to the depth
  always_comb begin
    if (32'(table_size) > 32'(TABLE_DEPTH)) begin
      eff_size = PW'(TABLE_DEPTH);
    end else begin
      eff_size = PW'(table_size);
    end
  end

  // one restoring remainder bit per cycle
  assign trial    = {rem, keysh[KEY_W-1]};
  assign rem_next = (trial >= {1'b0, sz}) ? PW'(trial - {1'b0, sz}) : PW'(trial);

  // pos advances by 2i+1, step kept reduced modulo the size
  assign pos_sum   = {1'b0, pos} + {1'b0, step};
  assign pos_next  = (pos_sum >= {1'b0, sz}) ? PW'(pos_sum - {1'b0, sz}) : PW'(pos_sum);
  assign step_sum  = {1'b0, step} + (PW + 1)'(2);
  assign step_next = (step_sum >= {1'b0, sz}) ? PW'(step_sum - {1'b0, sz}) : PW'(step_sum);

  assign sts.clear_last = (clr_addr == AW'(TABLE_DEPTH - 1));
  assign sts.size_zero  = (eff_size == '0);
  assign sts.div_last   = (cnt == CW'(KEY_W - 1));
  assign sts.slot_free  = !rd_data;
  assign sts.last_probe = (idx == sz - PW'(1));

  assign mem_we    = cmd.clear || cmd.mark;
  assign mem_waddr = cmd.clear ? clr_addr : pos[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      occ[mem_waddr] <= !cmd.clear;
    end
    rd_data <= occ[pos[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      keysh <= key;
      rem   <= '0;
      cnt   <= '0;
      sz    <= eff_size;
    end
    if (cmd.div_step) begin
      keysh <= {keysh[KEY_W-2:0], 1'b0};
      rem   <= rem_next;
      cnt   <= cnt + CW'(1);
    end
    if (cmd.probe_init) begin
      pos  <= rem;
      step <= (sz == PW'(1)) ? '0 : PW'(1);
      idx  <= '0;
    end
    if (cmd.advance) begin
      pos  <= pos_next;
      step <= step_next;
      idx  <= idx + PW'(1);
    end
    if (cmd.set_ok) begin
      pend_slot   <= pos[SLOT_W-1:0];
      pend_failed <= 1'b0;
    end
    if (cmd.set_fail) begin
      pend_slot   <= '0;
      pend_failed <= 1'b1;
    end
    if (cmd.publish) begin
      slot   <= pend_slot;
      failed <= pend_failed;
    end
  end

endmodule

`default_nettype wire

### src/quadratic_probe_hash_insert_unit.sv
// top level of the quadratic probe hash insert unit: config port, controller, datapath
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------
//   request  | req_valid, req_stall | key (31 bits)
//   response | rsp_valid, rsp_stall | slot (10 bits), failed
//   config   | psel, penable, pwrite| paddr, pwdata, prdata
//
// a request runs from acceptance to a waiting response through the bit-serial
// key modulo, a setup state, and a read and a check state per probe for the
// registered occupancy memory read and check; size zero goes straight to finish
// after reset, all TABLE_DEPTH entries of the occupancy memory are cleared, no requests taken
// a new request is taken while the last response is still stalled on the output
`default_nettype none

module quadratic_probe_hash_insert_unit #(
  parameter int TABLE_DEPTH = qph_pkg::DEPTH_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_valid,
  output logic                               req_stall,
  input  wire logic [qph_pkg::KEY_W-1:0]     key,
  output logic                               rsp_valid,
  input  wire logic                          rsp_stall,
  output logic      [qph_pkg::SLOT_W-1:0]    slot,
  output logic                               failed,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [qph_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [qph_pkg::PDATA_W-1:0]   pwdata,
  output logic      [qph_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready
);
  import qph_pkg::*;

  logic [SIZE_W-1:0] table_size;
  cmd_t              cmd;
  sts_t              sts;
  logic              reg_write;

  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= SIZE_RESET;
    end else if (reg_write && (paddr[2] == REG_TABLE_SIZE)) begin
      table_size <= pwdata[SIZE_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_TABLE_SIZE) begin
      prdata = PDATA_W'(table_size);
    end else begin
      prdata = '0;
    end
  end

  qph_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  qph_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .key        (key),
    .table_size (table_size),
    .cmd        (cmd),
    .sts        (sts),
    .slot       (slot),
    .failed     (failed)
  );

  // no request is taken while the memory clear runs
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> req_stall)
    else $error("request accepted during occupancy clear");

  // one request in flight at a time
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("second request accepted before the first finished");

  // a failed insert reports slot zero
  a_fail_slot: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && failed) |-> (slot == '0))
    else $error("failed insert with nonzero slot");

  // marking a slot never coincides with clearing or with a failure
  a_mark_excl: assert property (@(posedge clk) disable iff (rst)
    cmd.mark |-> (!cmd.clear && !cmd.set_fail))
    else $error("slot mark overlaps clear or failure");

endmodule

`default_nettype wire
